// ===== hdl/wsdf_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package wsdf_pkg;

  // Parser phase within one received segment.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXT_HI  = 3'd2,
    PH_EXT_LO  = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DROP    = 3'd6
  } phase_t;

  // Status codes carried with each result item.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EARLY  = 2'd1;
  localparam logic [1:0] ST_LEN127 = 2'd2;

  // Header constants.
  localparam logic [6:0]  LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0]  LEN_CODE_EXT64 = 7'd127;
  localparam logic [15:0] MASK_BYTES     = 16'd4;

  // One result item as held in the output queue.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       data_valid;
    logic [7:0] frame_type;
    logic       last;
    logic [1:0] status;
  } result_t;

endpackage : wsdf_pkg

`default_nettype wire

// ===== hdl/wsdf_byte_if.sv =====
// Valid/ready channel that carries received segment bytes.
`timescale 1ns / 1ps
`default_nettype none

interface wsdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       segment_end;

  modport source (output valid, output in_byte, output segment_end, input ready);
  modport sink   (input valid, input in_byte, input segment_end, output ready);
endinterface : wsdf_byte_if

`default_nettype wire

// ===== hdl/wsdf_result_if.sv =====
// Valid/ready channel that carries deframed result items.
`timescale 1ns / 1ps
`default_nettype none

interface wsdf_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       data_valid;
  logic [7:0] frame_type;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output payload_byte, output data_valid,
                  output frame_type, output last, output status, input ready);
  modport sink   (input valid, input payload_byte, input data_valid,
                  input frame_type, input last, input status, output ready);
endinterface : wsdf_result_if

`default_nettype wire

// ===== hdl/wsdf_result_fifo.sv =====
// Two-entry result queue: circular buffer with head and tail pointers.
`timescale 1ns / 1ps
`default_nettype none

module wsdf_result_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire wsdf_pkg::result_t push_data,
  output logic                   full,
  wsdf_result_if.source          tx
);
  import wsdf_pkg::*;

  result_t    mem [2];
  logic       head;
  logic       tail;
  logic [1:0] count;
  logic       pop;

  assign pop  = tx.valid && tx.ready;
  assign full = (count == 2'd2);

  // Storage is written at the tail; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // The head entry drives the output channel.
  assign tx.valid        = (count != 2'd0);
  assign tx.payload_byte = mem[head].payload_byte;
  assign tx.data_valid   = mem[head].data_valid;
  assign tx.frame_type   = mem[head].frame_type;
  assign tx.last         = mem[head].last;
  assign tx.status       = mem[head].status;

endmodule : wsdf_result_fifo

`default_nettype wire

// ===== hdl/websocket_frame_deframer_unit.sv =====
// Top level of the WebSocket frame deframer: header parse and payload unmask.
// A result item is pushed into the result queue when its byte is accepted.
// Throughput: one byte per cycle unless the result queue is full; the header
// decode and XOR are one pass of logic from the parser state registers into a
// two-entry result queue. Input is stalled only while both queue entries hold
// unread results. Reset (synchronous, active high) returns the parser to the
// idle phase and empties the result queue.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_unit (
  input  wire logic     clk,
  input  wire logic     rst,
  wsdf_byte_if.sink     rx,
  wsdf_result_if.source tx
);
  import wsdf_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  type_byte, type_byte_next;
  logic        mask_on, mask_on_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] byte_count, byte_count_next;
  logic [31:0] mask_key, mask_key_next;

  logic        accept;
  logic        fifo_full;
  logic        res_valid;
  result_t     res;

  logic        go_known;
  logic        go_done;
  logic        mask_sel;
  logic [15:0] len_val;
  logic [15:0] count_inc;
  logic [7:0]  key_byte;
  logic        fin;

  assign accept   = rx.valid && rx.ready;
  assign rx.ready = !fifo_full;

  assign count_inc = byte_count + 16'd1;

  // Mask byte for this payload position; the first mask byte sits on top.
  always_comb begin
    unique case (byte_count[1:0])
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      2'd3: key_byte = mask_key[7:0];
    endcase
  end

  assign fin = (count_inc == payload_length);

  // Per-byte header decode, unmask and result build.
  always_comb begin
    phase_next          = phase;
    type_byte_next      = type_byte;
    mask_on_next        = mask_on;
    payload_length_next = payload_length;
    byte_count_next     = byte_count;
    mask_key_next       = mask_key;
    go_known            = 1'b0;
    go_done             = 1'b0;
    mask_sel            = mask_on;
    len_val             = payload_length;
    res_valid           = 1'b0;
    res.payload_byte    = 8'd0;
    res.data_valid      = 1'b0;
    res.last            = 1'b0;
    res.status          = ST_OK;

    unique case (phase)
      PH_IDLE: begin
        type_byte_next      = rx.in_byte;
        mask_on_next        = 1'b0;
        payload_length_next = 16'd0;
        byte_count_next     = 16'd0;
        mask_key_next       = 32'd0;
        phase_next          = rx.in_byte[7] ? PH_LEN : PH_DROP;
      end
      PH_LEN: begin
        mask_on_next = rx.in_byte[7];
        if (rx.in_byte[6:0] == LEN_CODE_EXT64) begin
          res_valid  = 1'b1;
          res.last   = 1'b1;
          res.status = ST_LEN127;
          phase_next = PH_DROP;
        end else if (rx.in_byte[6:0] == LEN_CODE_EXT16) begin
          phase_next = PH_EXT_HI;
        end else begin
          payload_length_next = {9'd0, rx.in_byte[6:0]};
          len_val             = {9'd0, rx.in_byte[6:0]};
          mask_sel            = rx.in_byte[7];
          go_known            = 1'b1;
        end
      end
      PH_EXT_HI: begin
        payload_length_next = {rx.in_byte, 8'd0};
        phase_next          = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        payload_length_next = payload_length | {8'd0, rx.in_byte};
        len_val             = payload_length | {8'd0, rx.in_byte};
        go_known            = 1'b1;
      end
      PH_MASK: begin
        mask_key_next   = {mask_key[23:0], rx.in_byte};
        byte_count_next = count_inc;
        if (count_inc >= MASK_BYTES) begin
          go_done = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        byte_count_next  = count_inc;
        res_valid        = 1'b1;
        res.payload_byte = rx.in_byte ^ key_byte;
        res.data_valid   = 1'b1;
        res.last         = fin;
        if (fin) begin
          phase_next = PH_DROP;
        end
      end
      PH_DROP: begin
        phase_next = PH_DROP;
      end
      default: begin
        phase_next = phase;
      end
    endcase

    // Length is known: read the mask key next, or finish the header.
    if (go_known) begin
      if (mask_sel) begin
        byte_count_next = 16'd0;
        mask_key_next   = 32'd0;
        phase_next      = PH_MASK;
      end else begin
        go_done = 1'b1;
      end
    end

    // Header complete: an empty frame reports at once.
    if (go_done) begin
      byte_count_next = 16'd0;
      if (len_val == 16'd0) begin
        res_valid  = 1'b1;
        res.last   = 1'b1;
        res.status = ST_OK;
        phase_next = PH_DROP;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end

    // Segment end reports a truncated frame if one is open, then returns to idle.
    if (rx.segment_end) begin
      if (phase_next == PH_LEN || phase_next == PH_EXT_HI || phase_next == PH_EXT_LO ||
          phase_next == PH_MASK || phase_next == PH_PAYLOAD) begin
        if (!res_valid) begin
          res.payload_byte = 8'd0;
          res.data_valid   = 1'b0;
        end
        res_valid  = 1'b1;
        res.last   = 1'b1;
        res.status = ST_EARLY;
      end
      phase_next = PH_IDLE;
    end

    res.frame_type = type_byte_next;
  end

  // Parser state advances on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      type_byte      <= 8'd0;
      mask_on        <= 1'b0;
      payload_length <= 16'd0;
      byte_count     <= 16'd0;
      mask_key       <= 32'd0;
    end else if (accept) begin
      phase          <= phase_next;
      type_byte      <= type_byte_next;
      mask_on        <= mask_on_next;
      payload_length <= payload_length_next;
      byte_count     <= byte_count_next;
      mask_key       <= mask_key_next;
    end
  end

  // Result queue decouples the parser from output stalls.
  wsdf_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (fifo_full),
    .tx        (tx)
  );

endmodule : websocket_frame_deframer_unit

`default_nettype wire
